@@ rtl/core/lde_pkg.sv @@
// Shared types, constants and helpers for the Lorentz-dispersive E-field update core.
// No dependencies; every other file in rtl/core imports this package.
package lde_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COEF_WIDTH  = 32;
   localparam int CURL_WIDTH  = 31;
   localparam int FRAC_BITS   = 24;
   localparam int OSC_MAX     = 3;
   localparam int DIFF_WIDTH  = VALUE_WIDTH + 1;
   localparam int ACC_WIDTH   = 48;

   localparam int OSC_COUNT_DEFAULT   = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int REG_SEL_LSB    = 3;
   localparam int REG_SEL_WIDTH  = CSR_ADDR_WIDTH - REG_SEL_LSB;

   localparam logic [REG_SEL_WIDTH-1:0] REG_CURL_X    = REG_SEL_WIDTH'(0);
   localparam logic [REG_SEL_WIDTH-1:0] REG_CURL_Y    = REG_SEL_WIDTH'(1);
   localparam logic [REG_SEL_WIDTH-1:0] REG_CURL_Z    = REG_SEL_WIDTH'(2);
   localparam logic [REG_SEL_WIDTH-1:0] REG_OSC_ONE   = REG_SEL_WIDTH'(3);
   localparam logic [REG_SEL_WIDTH-1:0] REG_OSC_TWO   = REG_SEL_WIDTH'(4);
   localparam logic [REG_SEL_WIDTH-1:0] REG_OSC_THREE = REG_SEL_WIDTH'(5);

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef logic [2:0][CURL_WIDTH-1:0]      curl_set_type;
   typedef logic [OSC_MAX-1:0][COEF_WIDTH-1:0] osc_set_type;

   typedef struct packed {
      curl_set_type curl;
      osc_set_type  osc_a;
      osc_set_type  osc_b;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]              e;
      logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] pol;
      logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] pol_prev;
      logic [CURL_WIDTH-1:0]               coef_a;
      logic [CURL_WIDTH-1:0]               coef_b;
      logic [DIFF_WIDTH-1:0]               diff_a;
      logic [DIFF_WIDTH-1:0]               diff_b;
   } entry_type;

   // Clamps a wide signed sum to the signed range of VALUE_WIDTH bits.
   function automatic logic [VALUE_WIDTH-1:0] sat_value(input logic [ACC_WIDTH-1:0] v);
      logic [ACC_WIDTH-VALUE_WIDTH:0] top;
      top = v[ACC_WIDTH-1:VALUE_WIDTH-1];
      if ((&top) || !(|top)) begin
         return v[VALUE_WIDTH-1:0];
      end else if (v[ACC_WIDTH-1]) begin
         return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   endfunction

endpackage

@@ rtl/core/lde_csr.sv @@
// Configuration registers of the E-field update core behind an APB-style port.
// Depends on lde_pkg for register indexes and the configuration struct.
module lde_csr
   import lde_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic [2:0][CURL_WIDTH-1:0]         curl_ff;
   logic [OSC_MAX-1:0][2*COEF_WIDTH-1:0] osc_ff;
   logic [REG_SEL_WIDTH-1:0]           sel;
   logic                               wr_en;

   assign pready = 1'b1;
   assign sel    = paddr[CSR_ADDR_WIDTH-1:REG_SEL_LSB];
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         curl_ff <= '0;
         osc_ff  <= '0;
      end else if (wr_en) begin
         unique case (sel)
            REG_CURL_X:    curl_ff[0] <= pwdata[CURL_WIDTH-1:0];
            REG_CURL_Y:    curl_ff[1] <= pwdata[CURL_WIDTH-1:0];
            REG_CURL_Z:    curl_ff[2] <= pwdata[CURL_WIDTH-1:0];
            REG_OSC_ONE:   osc_ff[0]  <= pwdata;
            REG_OSC_TWO:   osc_ff[1]  <= pwdata;
            REG_OSC_THREE: osc_ff[2]  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_CURL_X:    prdata = CSR_DATA_WIDTH'(curl_ff[0]);
         REG_CURL_Y:    prdata = CSR_DATA_WIDTH'(curl_ff[1]);
         REG_CURL_Z:    prdata = CSR_DATA_WIDTH'(curl_ff[2]);
         REG_OSC_ONE:   prdata = osc_ff[0];
         REG_OSC_TWO:   prdata = osc_ff[1];
         REG_OSC_THREE: prdata = osc_ff[2];
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      cfg.curl = curl_ff;
      for (int n = 0; n < OSC_MAX; n++) begin
         cfg.osc_a[n] = osc_ff[n][2*COEF_WIDTH-1:COEF_WIDTH];
         cfg.osc_b[n] = osc_ff[n][COEF_WIDTH-1:0];
      end
   end

endmodule

@@ rtl/core/lde_front.sv @@
// Front end: accepts an item, picks the curl coefficients for its component and
// forms the two backward differences. Depends on lde_pkg.
module lde_front
   import lde_pkg::*;
(
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_component,
   input  logic [VALUE_WIDTH-1:0] req_e_self,
   input  logic [VALUE_WIDTH-1:0] req_pol_one,
   input  logic [VALUE_WIDTH-1:0] req_pol_two,
   input  logic [VALUE_WIDTH-1:0] req_pol_three,
   input  logic [VALUE_WIDTH-1:0] req_pol_one_prev,
   input  logic [VALUE_WIDTH-1:0] req_pol_two_prev,
   input  logic [VALUE_WIDTH-1:0] req_pol_three_prev,
   input  logic [VALUE_WIDTH-1:0] req_mag_a_here,
   input  logic [VALUE_WIDTH-1:0] req_mag_a_back,
   input  logic [VALUE_WIDTH-1:0] req_mag_b_here,
   input  logic [VALUE_WIDTH-1:0] req_mag_b_back,
   input  curl_set_type           curl,
   input  logic                   queue_full,
   output logic                   push,
   output entry_type              entry
);

   logic [CURL_WIDTH-1:0] coef_a;
   logic [CURL_WIDTH-1:0] coef_b;

   assign busy = queue_full;
   assign push = start && !queue_full;

   // The unused selector code has no axis, so its curl comes out as zero.
   always_comb begin
      unique case (req_component)
         COMP_X: begin
            coef_a = curl[1];
            coef_b = curl[2];
         end
         COMP_Y: begin
            coef_a = curl[2];
            coef_b = curl[0];
         end
         COMP_Z: begin
            coef_a = curl[0];
            coef_b = curl[1];
         end
         default: begin
            coef_a = '0;
            coef_b = '0;
         end
      endcase
   end

   always_comb begin
      entry.e           = req_e_self;
      entry.pol[0]      = req_pol_one;
      entry.pol[1]      = req_pol_two;
      entry.pol[2]      = req_pol_three;
      entry.pol_prev[0] = req_pol_one_prev;
      entry.pol_prev[1] = req_pol_two_prev;
      entry.pol_prev[2] = req_pol_three_prev;
      entry.coef_a      = coef_a;
      entry.coef_b      = coef_b;
      entry.diff_a      = DIFF_WIDTH'($signed(req_mag_a_here))
                        - DIFF_WIDTH'($signed(req_mag_a_back));
      entry.diff_b      = DIFF_WIDTH'($signed(req_mag_b_here))
                        - DIFF_WIDTH'($signed(req_mag_b_back));
   end

endmodule

@@ rtl/core/lde_queue.sv @@
// Short FIFO of classified items between the front end and the datapath.
// Depends on lde_pkg for the entry type. DEPTH must be at least 2.
module lde_queue
   import lde_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type entry_in,
   input  logic      pop,
   output entry_type entry_out,
   output logic      full,
   output logic      empty
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   entry_type              mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_pop    = pop && !empty;
   assign entry_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ rtl/core/lde_back.sv @@
// Datapath: four-stage pipeline for the oscillator updates, the curl and the
// saturated field result. Depends on lde_pkg for types and saturation.
module lde_back
   import lde_pkg::*;
#(
   parameter int OSC_COUNT = OSC_COUNT_DEFAULT
)(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  entry_type                           entry,
   input  osc_set_type                         osc_a,
   input  osc_set_type                         osc_b,
   output logic                                out_valid,
   output logic [VALUE_WIDTH-1:0]              out_e,
   output logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] out_pol
);

   localparam int PROD_WIDTH  = COEF_WIDTH + VALUE_WIDTH;
   localparam int NEG_WIDTH   = PROD_WIDTH + 1;
   localparam int CPROD_WIDTH = CURL_WIDTH + 1 + DIFF_WIDTH;

   // Stage 1: products.
   logic                                 s1_valid_ff;
   logic signed [OSC_MAX-1:0][PROD_WIDTH-1:0] s1_ap_ff, s1_ap_in;
   logic signed [OSC_MAX-1:0][PROD_WIDTH-1:0] s1_be_ff, s1_be_in;
   logic signed [CPROD_WIDTH-1:0]        s1_ca_ff, s1_ca_in;
   logic signed [CPROD_WIDTH-1:0]        s1_cb_ff, s1_cb_in;
   logic [VALUE_WIDTH-1:0]               s1_e_ff;
   logic [OSC_MAX-1:0][VALUE_WIDTH-1:0]  s1_pol_ff;
   logic [OSC_MAX-1:0][VALUE_WIDTH-1:0]  s1_prev_ff;

   // Stage 2: rounded terms, curl and the old sum.
   logic                                 s2_valid_ff;
   logic [OSC_MAX-1:0][ACC_WIDTH-1:0]    s2_ap_ff, s2_ap_in;
   logic [OSC_MAX-1:0][ACC_WIDTH-1:0]    s2_be_ff, s2_be_in;
   logic [OSC_MAX-1:0][ACC_WIDTH-1:0]    s2_lin_ff, s2_lin_in;
   logic [ACC_WIDTH-1:0]                 s2_curl_ff, s2_curl_in;
   logic [ACC_WIDTH-1:0]                 s2_old_ff, s2_old_in;

   // Stage 3: saturated polarizations and the field base.
   logic                                 s3_valid_ff;
   logic [OSC_MAX-1:0][VALUE_WIDTH-1:0]  s3_pnew_ff, s3_pnew_in;
   logic [ACC_WIDTH-1:0]                 s3_base_ff, s3_base_in;

   // Stage 4: result registers.
   logic                                 out_valid_ff;
   logic [VALUE_WIDTH-1:0]               out_e_ff, out_e_in;
   logic [OSC_MAX-1:0][VALUE_WIDTH-1:0]  out_pol_ff;

   always_comb begin
      for (int n = 0; n < OSC_MAX; n++) begin
         s1_ap_in[n] = $signed(osc_a[n]) * $signed(entry.pol[n]);
         s1_be_in[n] = $signed(osc_b[n]) * $signed(entry.e);
      end
      s1_ca_in = $signed({1'b0, entry.coef_a}) * $signed(entry.diff_a);
      s1_cb_in = $signed({1'b0, entry.coef_b}) * $signed(entry.diff_b);
   end

   // Each product is shifted down on its own, rounding toward minus infinity.
   always_comb begin
      logic signed [NEG_WIDTH-1:0] neg;
      logic [ACC_WIDTH-1:0]        sum;
      sum = ACC_WIDTH'($signed(s1_e_ff));
      for (int n = 0; n < OSC_MAX; n++) begin
         neg          = -NEG_WIDTH'($signed(s1_ap_ff[n]));
         s2_ap_in[n]  = ACC_WIDTH'($signed(neg[NEG_WIDTH-1:FRAC_BITS]));
         s2_be_in[n]  = ACC_WIDTH'($signed(s1_be_ff[n][PROD_WIDTH-1:FRAC_BITS]));
         s2_lin_in[n] = (ACC_WIDTH'($signed(s1_pol_ff[n])) <<< 1)
                      - ACC_WIDTH'($signed(s1_prev_ff[n]));
         if (n < OSC_COUNT) begin
            sum = sum + ACC_WIDTH'($signed(s1_pol_ff[n]));
         end
      end
      s2_old_in  = sum;
      s2_curl_in = ACC_WIDTH'($signed(s1_ca_ff[CPROD_WIDTH-1:FRAC_BITS]))
                 - ACC_WIDTH'($signed(s1_cb_ff[CPROD_WIDTH-1:FRAC_BITS]));
   end

   // Oscillators beyond the configured count report zero and drop out of the sums.
   always_comb begin
      for (int n = 0; n < OSC_MAX; n++) begin
         if (n < OSC_COUNT) begin
            s3_pnew_in[n] = sat_value(s2_lin_ff[n] + s2_ap_ff[n] + s2_be_ff[n]);
         end else begin
            s3_pnew_in[n] = '0;
         end
      end
      s3_base_in = s2_old_ff + s2_curl_ff;
   end

   always_comb begin
      logic [ACC_WIDTH-1:0] acc;
      acc = s3_base_ff;
      for (int n = 0; n < OSC_MAX; n++) begin
         acc = acc - ACC_WIDTH'($signed(s3_pnew_ff[n]));
      end
      out_e_in = sat_value(acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ap_ff   <= s1_ap_in;
      s1_be_ff   <= s1_be_in;
      s1_ca_ff   <= s1_ca_in;
      s1_cb_ff   <= s1_cb_in;
      s1_e_ff    <= entry.e;
      s1_pol_ff  <= entry.pol;
      s1_prev_ff <= entry.pol_prev;
      s2_ap_ff   <= s2_ap_in;
      s2_be_ff   <= s2_be_in;
      s2_lin_ff  <= s2_lin_in;
      s2_curl_ff <= s2_curl_in;
      s2_old_ff  <= s2_old_in;
      s3_pnew_ff <= s3_pnew_in;
      s3_base_ff <= s3_base_in;
      out_e_ff   <= out_e_in;
      out_pol_ff <= s3_pnew_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_e     = out_e_ff;
   assign out_pol   = out_pol_ff;

endmodule

@@ rtl/core/lorentz_dispersive_e_field_update_core.sv @@
// Lorentz-dispersive E-field update for one Yee cell component, top level.
// Instantiates lde_csr, lde_front, lde_queue and lde_back; depends on lde_pkg.
//
// Usage:
//   Items enter on the req_ ports and are taken at a clock edge where start is
//   high and busy is low. The datapath drains the queue every cycle, so busy
//   stays low in normal operation and one item can be taken every cycle.
//   Each item produces exactly one result: rsp_valid is high for one cycle with
//   rsp_e_new and the three rsp_pol_*_new values on the rsp_ ports.
//   Path: each taken item waits in the queue, then passes four pipeline stages
//   for the multiply, rounding, oscillator sum and field saturation steps.
//   Throughput: one item per cycle while busy is low.
//   The receiver cannot stall; results are never held back.
//   Configuration: six registers at byte addresses 0, 8, ..., 40 (curl
//   coefficients x, y, z, then the three oscillator coefficient pairs). The user
//   must see that they are written only while no item is in flight.
//   The block does not enforce this. pready is always high. Reset (synchronous,
//   active high) empties the queue and pipeline and clears all configuration registers to zero.
module lorentz_dispersive_e_field_update_core
   import lde_pkg::*;
#(
   parameter int OSC_COUNT   = OSC_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_component,
   input  logic [VALUE_WIDTH-1:0]    req_e_self,
   input  logic [VALUE_WIDTH-1:0]    req_pol_one,
   input  logic [VALUE_WIDTH-1:0]    req_pol_two,
   input  logic [VALUE_WIDTH-1:0]    req_pol_three,
   input  logic [VALUE_WIDTH-1:0]    req_pol_one_prev,
   input  logic [VALUE_WIDTH-1:0]    req_pol_two_prev,
   input  logic [VALUE_WIDTH-1:0]    req_pol_three_prev,
   input  logic [VALUE_WIDTH-1:0]    req_mag_a_here,
   input  logic [VALUE_WIDTH-1:0]    req_mag_a_back,
   input  logic [VALUE_WIDTH-1:0]    req_mag_b_here,
   input  logic [VALUE_WIDTH-1:0]    req_mag_b_back,
   output logic                      rsp_valid,
   output logic [VALUE_WIDTH-1:0]    rsp_e_new,
   output logic [VALUE_WIDTH-1:0]    rsp_pol_one_new,
   output logic [VALUE_WIDTH-1:0]    rsp_pol_two_new,
   output logic [VALUE_WIDTH-1:0]    rsp_pol_three_new,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type                             cfg;
   entry_type                           push_entry;
   entry_type                           pop_entry;
   logic                                push;
   logic                                queue_full;
   logic                                queue_empty;
   logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] pol_new;

   lde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lde_front u_front (
      .start              (start),
      .busy               (busy),
      .req_component      (req_component),
      .req_e_self         (req_e_self),
      .req_pol_one        (req_pol_one),
      .req_pol_two        (req_pol_two),
      .req_pol_three      (req_pol_three),
      .req_pol_one_prev   (req_pol_one_prev),
      .req_pol_two_prev   (req_pol_two_prev),
      .req_pol_three_prev (req_pol_three_prev),
      .req_mag_a_here     (req_mag_a_here),
      .req_mag_a_back     (req_mag_a_back),
      .req_mag_b_here     (req_mag_b_here),
      .req_mag_b_back     (req_mag_b_back),
      .curl               (cfg.curl),
      .queue_full         (queue_full),
      .push               (push),
      .entry              (push_entry)
   );

   lde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (push_entry),
      .pop       (!queue_empty),
      .entry_out (pop_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   lde_back #(
      .OSC_COUNT (OSC_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!queue_empty),
      .entry     (pop_entry),
      .osc_a     (cfg.osc_a),
      .osc_b     (cfg.osc_b),
      .out_valid (rsp_valid),
      .out_e     (rsp_e_new),
      .out_pol   (pol_new)
   );

   assign rsp_pol_one_new   = pol_new[0];
   assign rsp_pol_two_new   = pol_new[1];
   assign rsp_pol_three_new = pol_new[2];

endmodule

@@ rtl/core/lde_checker.sv @@
// Port-level checks for the E-field update core, attached to the top level by bind.
// Depends on lde_pkg for register indexes and port widths.
module lde_checker
   import lde_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic                      psel,
   input logic                      penable,
   input logic                      pwrite,
   input logic                      pready,
   input logic [CSR_ADDR_WIDTH-1:0] paddr,
   input logic [CSR_DATA_WIDTH-1:0] pwdata,
   input logic [CSR_DATA_WIDTH-1:0] prdata
);

   // Every taken item yields its result after the fixed pipeline latency.
   a_result_follows_item: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid
   ) else $error("item taken without a result five cycles later");

   // No result appears without an item taken at the matching time.
   a_no_spurious_result: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5)
   ) else $error("result strobe without a matching item");

   // A write to the first oscillator register reads back the written value.
   a_osc_readback: assert property (
      @(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready
         && paddr[CSR_ADDR_WIDTH-1:REG_SEL_LSB] == REG_OSC_ONE)
      ##1 (paddr[CSR_ADDR_WIDTH-1:REG_SEL_LSB] == REG_OSC_ONE)
      |-> prdata == $past(pwdata)
   ) else $error("oscillator register read back differs from written data");

endmodule

bind lorentz_dispersive_e_field_update_core lde_checker u_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for lorentz_dispersive_e_field_update_core.
// Drives cell items and APB register writes, predicts each field update in a small
// scoreboard class and compares every result field. Depends on lde_pkg and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lde_pkg::*;

   localparam logic [1:0] COMP_NONE = 2'd3;
   localparam logic [REG_SEL_WIDTH-1:0] REG_SPARE_LO = REG_SEL_WIDTH'(6);
   localparam logic [REG_SEL_WIDTH-1:0] REG_SPARE_HI = REG_SEL_WIDTH'(7);
   localparam logic [VALUE_WIDTH-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [CSR_DATA_WIDTH-1:0] CURL_MAX = 64'h0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] VALUE_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] VALUE_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic [1:0]                          comp;
      logic [VALUE_WIDTH-1:0]              e;
      logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] pol;
      logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] pol_prev;
      logic [VALUE_WIDTH-1:0]              a_here;
      logic [VALUE_WIDTH-1:0]              a_back;
      logic [VALUE_WIDTH-1:0]              b_here;
      logic [VALUE_WIDTH-1:0]              b_back;
   } cell_item_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]              e_new;
      logic [OSC_MAX-1:0][VALUE_WIDTH-1:0] pol_new;
   } field_update_type;

   class yee_update_model;
      logic [CURL_WIDTH-1:0]     curl_coef [3];
      logic [CSR_DATA_WIDTH-1:0] osc_coef [3];
      field_update_type          pending_updates [$];
      int                        mismatches;

      function new();
         foreach (curl_coef[i]) curl_coef[i] = '0;
         foreach (osc_coef[i]) osc_coef[i] = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [REG_SEL_WIDTH-1:0] sel,
                                 logic [CSR_DATA_WIDTH-1:0] value);
         case (sel)
            REG_CURL_X:    curl_coef[0] = value[CURL_WIDTH-1:0];
            REG_CURL_Y:    curl_coef[1] = value[CURL_WIDTH-1:0];
            REG_CURL_Z:    curl_coef[2] = value[CURL_WIDTH-1:0];
            REG_OSC_ONE:   osc_coef[0] = value;
            REG_OSC_TWO:   osc_coef[1] = value;
            REG_OSC_THREE: osc_coef[2] = value;
            default: ;
         endcase
      endfunction

      function logic [VALUE_WIDTH-1:0] clamp(logic signed [63:0] v);
         if (v > VALUE_MAX) begin
            return Q_MAX;
         end else if (v < VALUE_MIN) begin
            return Q_MIN;
         end else begin
            return v[VALUE_WIDTH-1:0];
         end
      endfunction

      // Every Q8.24 product is exact in 64 bits; an arithmetic shift rounds it
      // toward minus infinity. Only the final sums are clamped.
      function field_update_type compute_update(cell_item_type item);
         field_update_type   upd;
         logic signed [63:0] e, p, pp, a, b, t, sum_old, sum_new;
         logic signed [63:0] da, db, ca, cb, curl;
         e = $signed(item.e);
         sum_old = 0;
         sum_new = 0;
         for (int n = 0; n < OSC_MAX; n++) begin
            p = $signed(item.pol[n]);
            pp = $signed(item.pol_prev[n]);
            a = $signed(osc_coef[n][63:32]);
            b = $signed(osc_coef[n][31:0]);
            t = 2 * p + ((-(a * p)) >>> FRAC_BITS) + ((b * e) >>> FRAC_BITS) - pp;
            upd.pol_new[n] = clamp(t);
            sum_old += p;
            sum_new += $signed(upd.pol_new[n]);
         end
         case (item.comp)
            COMP_X: begin
               ca = curl_coef[1];
               cb = curl_coef[2];
            end
            COMP_Y: begin
               ca = curl_coef[2];
               cb = curl_coef[0];
            end
            COMP_Z: begin
               ca = curl_coef[0];
               cb = curl_coef[1];
            end
            default: begin
               ca = 0;
               cb = 0;
            end
         endcase
         da = $signed(item.a_here) - $signed(item.a_back);
         db = $signed(item.b_here) - $signed(item.b_back);
         curl = ((ca * da) >>> FRAC_BITS) - ((cb * db) >>> FRAC_BITS);
         upd.e_new = clamp(e + sum_old - sum_new + curl);
         return upd;
      endfunction

      function void note_cell(cell_item_type item);
         pending_updates.push_back(compute_update(item));
      endfunction

      function void compare_field(string name, logic [VALUE_WIDTH-1:0] want,
                                  logic [VALUE_WIDTH-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
         end
      endfunction

      function void check_update(logic [VALUE_WIDTH-1:0] e_new, logic [VALUE_WIDTH-1:0] p1,
                                 logic [VALUE_WIDTH-1:0] p2, logic [VALUE_WIDTH-1:0] p3);
         field_update_type want;
         if (pending_updates.size() == 0) begin
            $error("result arrived with no item outstanding");
            mismatches++;
            return;
         end
         want = pending_updates.pop_front();
         compare_field("e_new", want.e_new, e_new);
         compare_field("pol_one_new", want.pol_new[0], p1);
         compare_field("pol_two_new", want.pol_new[1], p2);
         compare_field("pol_three_new", want.pol_new[2], p3);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   cell_item_type             drive_cell = '0;
   logic                      rsp_valid;
   logic [VALUE_WIDTH-1:0]    rsp_e_new;
   logic [VALUE_WIDTH-1:0]    rsp_pol_one_new;
   logic [VALUE_WIDTH-1:0]    rsp_pol_two_new;
   logic [VALUE_WIDTH-1:0]    rsp_pol_three_new;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   yee_update_model cell_model;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lorentz_dispersive_e_field_update_core DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_component      (drive_cell.comp),
      .req_e_self         (drive_cell.e),
      .req_pol_one        (drive_cell.pol[0]),
      .req_pol_two        (drive_cell.pol[1]),
      .req_pol_three      (drive_cell.pol[2]),
      .req_pol_one_prev   (drive_cell.pol_prev[0]),
      .req_pol_two_prev   (drive_cell.pol_prev[1]),
      .req_pol_three_prev (drive_cell.pol_prev[2]),
      .req_mag_a_here     (drive_cell.a_here),
      .req_mag_a_back     (drive_cell.a_back),
      .req_mag_b_here     (drive_cell.b_here),
      .req_mag_b_back     (drive_cell.b_back),
      .rsp_valid          (rsp_valid),
      .rsp_e_new          (rsp_e_new),
      .rsp_pol_one_new    (rsp_pol_one_new),
      .rsp_pol_two_new    (rsp_pol_two_new),
      .rsp_pol_three_new  (rsp_pol_three_new),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // Inputs change only through nonblocking assignments, so the values seen
   // here at the edge are the ones the block samples.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         cell_model.note_cell(drive_cell);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         cell_model.check_update(rsp_e_new, rsp_pol_one_new, rsp_pol_two_new,
                                 rsp_pol_three_new);
      end
   end

   task automatic send_cell(cell_item_type item);
      drive_cell <= item;
      start <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   task automatic rest(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_updates();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (cell_model.pending_updates.size() != 0);
   endtask

   // Leaves the bus selected so that back-to-back writes need not release it in between.
   task automatic csr_write(logic [REG_SEL_WIDTH-1:0] sel, logic [CSR_DATA_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_WIDTH'(sel) << REG_SEL_LSB;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      cell_model.set_register(sel, value);
   endtask

   task automatic load_config(logic [CSR_DATA_WIDTH-1:0] cx, logic [CSR_DATA_WIDTH-1:0] cy,
                              logic [CSR_DATA_WIDTH-1:0] cz, logic [CSR_DATA_WIDTH-1:0] o1,
                              logic [CSR_DATA_WIDTH-1:0] o2, logic [CSR_DATA_WIDTH-1:0] o3);
      csr_write(REG_CURL_X, cx);
      csr_write(REG_CURL_Y, cy);
      csr_write(REG_CURL_Z, cz);
      csr_write(REG_OSC_ONE, o1);
      csr_write(REG_OSC_TWO, o2);
      csr_write(REG_OSC_THREE, o3);
      // Addresses past the last register must not disturb anything.
      csr_write(REG_SPARE_LO, {$urandom(), $urandom()});
      csr_write(REG_SPARE_HI, {$urandom(), $urandom()});
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic cell_item_type make_cell(logic [1:0] comp, logic [VALUE_WIDTH-1:0] e,
                                               logic [VALUE_WIDTH-1:0] pol,
                                               logic [VALUE_WIDTH-1:0] prev,
                                               logic [VALUE_WIDTH-1:0] ah,
                                               logic [VALUE_WIDTH-1:0] ab,
                                               logic [VALUE_WIDTH-1:0] bh,
                                               logic [VALUE_WIDTH-1:0] bb);
      cell_item_type item;
      item.comp = comp;
      item.e = e;
      item.pol = {pol, pol, pol};
      item.pol_prev = {prev, prev, prev};
      item.a_here = ah;
      item.a_back = ab;
      item.b_here = bh;
      item.b_back = bb;
      return item;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 7))
         0, 1, 2: return r;
         3, 4:    return {{7{r[24]}}, r[24:0]};
         5:       return {{16{r[15]}}, r[15:0]};
         6:       return Q_MAX;
         default: return Q_MIN;
      endcase
   endfunction

   function automatic cell_item_type random_cell();
      cell_item_type item;
      case ($urandom_range(0, 9))
         0:       item.comp = COMP_NONE;
         1, 2, 3: item.comp = COMP_X;
         4, 5, 6: item.comp = COMP_Y;
         default: item.comp = COMP_Z;
      endcase
      item.e = random_sample();
      for (int n = 0; n < OSC_MAX; n++) begin
         item.pol[n] = random_sample();
         item.pol_prev[n] = random_sample();
      end
      item.a_here = random_sample();
      item.a_back = random_sample();
      item.b_here = random_sample();
      item.b_back = random_sample();
      return item;
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] random_curl();
      case ($urandom_range(0, 5))
         0, 1, 2: return 64'($urandom_range(0, 32'h0100_0000));
         3:       return {$urandom(), $urandom()};
         4:       return CURL_MAX;
         default: return '0;
      endcase
   endfunction

   function automatic logic [31:0] random_osc_half();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 5))
         0, 1, 2: return {{6{r[25]}}, r[25:0]};
         3:       return r;
         4:       return Q_MAX;
         default: return Q_MIN;
      endcase
   endfunction

   task automatic run_random(int count, bit with_gaps);
      for (int i = 0; i < count; i++) begin
         if (with_gaps && $urandom_range(0, 3) == 0) begin
            rest($urandom_range(1, 3));
         end
         send_cell(random_cell());
      end
   endtask

   initial begin
      cell_model = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Registers still at their reset values: no curl and no coupling to the field.
      send_cell(make_cell(COMP_X, 32'h0100_0000, 32'h0080_0000, 32'h0040_0000,
                          32'h0200_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0180_0000));
      send_cell(make_cell(COMP_Y, 32'hFF00_0000, 32'h0080_0000, 32'hFFC0_0000,
                          32'h0200_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0180_0000));
      send_cell(make_cell(COMP_Z, 32'h0100_0000, 32'hFF80_0000, 32'h0040_0000,
                          32'h0200_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0180_0000));
      send_cell(make_cell(COMP_NONE, 32'h0100_0000, 32'h0080_0000, 32'h0040_0000,
                          32'h0200_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0180_0000));
      drain_updates();

      // Physically plausible setting; the first two curl writes carry junk above bit 30.
      load_config(64'hFFFF_FFFF_8080_0000, 64'h0000_0001_0040_0000, 64'h0000_0000_0020_0000,
                  {32'h0001_0000, 32'h0000_8000}, {32'h0004_0000, 32'hFFFF_0000},
                  {32'hFFFE_0000, 32'h0002_0000});
      send_cell(make_cell(COMP_X, 32'h0120_0000, 32'h0030_0000, 32'h0028_0000,
                          32'h0150_0000, 32'hFFE0_0000, 32'h0010_0000, 32'hFF70_0000));
      send_cell(make_cell(COMP_Y, 32'hFEE0_0000, 32'hFFD0_0000, 32'h0028_0000,
                          32'h0150_0000, 32'hFFE0_0000, 32'h0010_0000, 32'hFF70_0000));
      send_cell(make_cell(COMP_Z, 32'h0120_0000, 32'h0030_0000, 32'hFFD8_0000,
                          32'h0150_0000, 32'hFFE0_0000, 32'h0010_0000, 32'hFF70_0000));
      send_cell(make_cell(COMP_NONE, 32'h0120_0000, 32'h0030_0000, 32'h0028_0000,
                          32'h0150_0000, 32'hFFE0_0000, 32'h0010_0000, 32'hFF70_0000));
      send_cell(make_cell(COMP_X, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_cell(make_cell(COMP_Y, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_cell(make_cell(COMP_Z, '0, '0, '0, '0, '0, '0, '0));
      // Polarization driven past either rail.
      send_cell(make_cell(COMP_X, 32'h0100_0000, Q_MAX, Q_MIN, '0, '0, '0, '0));
      send_cell(make_cell(COMP_Y, 32'hFF00_0000, Q_MIN, Q_MAX, '0, '0, '0, '0));
      // Largest curl differences push the field past the rails for the three axis components.
      send_cell(make_cell(COMP_X, Q_MAX, '0, '0, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
      send_cell(make_cell(COMP_Z, Q_MIN, '0, '0, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
      send_cell(make_cell(COMP_Y, Q_MAX, '0, '0, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
      send_cell(make_cell(COMP_NONE, Q_MAX, '0, '0, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
      run_random(200, 1'b1);
      drain_updates();

      load_config(CURL_MAX, CURL_MAX, CURL_MAX, {Q_MAX, Q_MAX}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MAX});
      run_random(150, 1'b1);
      drain_updates();

      load_config('0, '0, '0, '0, '0, '0);
      run_random(100, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         drain_updates();
         load_config(random_curl(), random_curl(), random_curl(),
                     {random_osc_half(), random_osc_half()},
                     {random_osc_half(), random_osc_half()},
                     {random_osc_half(), random_osc_half()});
         run_random(170, phase != 5);
      end

      drain_updates();
      repeat (10) @(posedge clock);
      if (cell_model.mismatches == 0 && cell_model.pending_updates.size() == 0) begin
         $display("lorentz_dispersive_e_field_update_core test passed");
      end else begin
         $display("lorentz_dispersive_e_field_update_core test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("lorentz_dispersive_e_field_update_core test failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/lde_pkg.sv
rtl/core/lde_csr.sv
rtl/core/lde_front.sv
rtl/core/lde_queue.sv
rtl/core/lde_back.sv
rtl/core/lorentz_dispersive_e_field_update_core.sv
rtl/core/lde_checker.sv
tb/sv/testbench.sv
